@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the piece table lookup RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge while the synchronous reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALL(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/ptpl_pkg.sv @@
// ----------------------------------------------------------------------------
// Piece table lookup package
// Shared widths, opcodes and the request record that walks the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptpl_pkg;

    localparam int MAX_PIECES_DEF = 256;
    localparam int IDX_W          = 9;
    localparam int WORD_W         = 32;

    typedef enum logic [1:0] {
        OP_WR_BND  = 2'd0,
        OP_WR_DESC = 2'd1,
        OP_QUERY   = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    // One request in flight. For a query, word_b holds the position until a
    // cell matches; from then on word_a is the boundary and word_b the
    // descriptor of the matching piece.
    typedef struct packed {
        logic                valid;
        t_op                 op;
        logic [IDX_W-1:0]    idx;
        logic [WORD_W-1:0]   word_a;
        logic [WORD_W-1:0]   word_b;
        logic                hit;
    } t_stage;

endpackage

@@ rtl/core/ptpl_cell.sv @@
// ----------------------------------------------------------------------------
// Piece table cell
// Holds one piece: its upper boundary and its descriptor, and tests queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptpl_cell #(
    parameter int K = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic [ptpl_pkg::IDX_W-1:0] i_cnt,
    input  ptpl_pkg::t_stage         i_stage,
    output ptpl_pkg::t_stage         o_stage
);

    localparam logic [31:0] K_W      = 32'(K);
    localparam logic [31:0] K_NEXT_W = 32'(K + 1);
    localparam logic [ptpl_pkg::IDX_W-1:0] K_IDX = ptpl_pkg::IDX_W'(K);

    logic [ptpl_pkg::WORD_W-1:0] r_bnd;
    logic [ptpl_pkg::WORD_W-1:0] r_desc;
    ptpl_pkg::t_stage            r_stage;
    ptpl_pkg::t_stage            n_stage;

    logic [31:0] idx_w;
    logic [31:0] cnt_w;
    logic        wr_bnd;
    logic        wr_desc;
    logic        hit;

    assign idx_w = {{(32 - ptpl_pkg::IDX_W){1'b0}}, i_stage.idx};
    assign cnt_w = {{(32 - ptpl_pkg::IDX_W){1'b0}}, i_cnt};

    // This cell stores boundary entry K+1 and descriptor entry K.
    assign wr_bnd  = i_stage.valid && (i_stage.op == ptpl_pkg::OP_WR_BND)
                     && (idx_w == K_NEXT_W);
    assign wr_desc = i_stage.valid && (i_stage.op == ptpl_pkg::OP_WR_DESC)
                     && (idx_w == K_W);
    assign hit     = i_stage.valid && (i_stage.op == ptpl_pkg::OP_QUERY)
                     && !i_stage.hit && (K_W < cnt_w) && (r_bnd > i_stage.word_b);

    always_comb begin
        n_stage = i_stage;
        if (hit) begin
            n_stage.hit    = 1'b1;
            n_stage.idx    = K_IDX;
            n_stage.word_a = r_bnd;
            n_stage.word_b = r_desc;
        end
    end

    // Only the valid bit is reset; the payload follows it through the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_adv) begin
            r_stage.op     <= n_stage.op;
            r_stage.idx    <= n_stage.idx;
            r_stage.word_a <= n_stage.word_a;
            r_stage.word_b <= n_stage.word_b;
            r_stage.hit    <= n_stage.hit;
            if (wr_bnd) begin
                r_bnd <= i_stage.word_a;
            end
            if (wr_desc) begin
                r_desc <= i_stage.word_a;
            end
        end
    end

    assign o_stage = r_stage;

endmodule

@@ rtl/core/ptpl_out.sv @@
// ----------------------------------------------------------------------------
// Piece table result register
// Formats the request leaving the chain and holds it until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptpl_out (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic [ptpl_pkg::IDX_W-1:0]  i_cnt,
    input  ptpl_pkg::t_stage            i_stage,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [ptpl_pkg::IDX_W-1:0]  o_piece_index,
    output logic [ptpl_pkg::WORD_W-1:0] o_next_boundary,
    output logic                        o_wide_chars,
    output logic [ptpl_pkg::WORD_W-1:0] o_file_offset
);

    logic                        r_valid;
    logic                        r_found;
    logic [ptpl_pkg::IDX_W-1:0]  r_piece_index;
    logic [ptpl_pkg::WORD_W-1:0] r_next_boundary;
    logic                        r_wide_chars;
    logic [ptpl_pkg::WORD_W-1:0] r_file_offset;

    logic                        n_found;
    logic [ptpl_pkg::IDX_W-1:0]  n_piece_index;
    logic [ptpl_pkg::WORD_W-1:0] n_next_boundary;
    logic                        n_wide_chars;
    logic [ptpl_pkg::WORD_W-1:0] n_file_offset;
    logic [ptpl_pkg::WORD_W-1:0] desc;

    assign desc = i_stage.word_b;

    always_comb begin
        n_found         = 1'b0;
        n_piece_index   = i_cnt;
        n_next_boundary = '0;
        n_wide_chars    = 1'b0;
        n_file_offset   = '0;
        if (i_stage.hit) begin
            n_found         = 1'b1;
            n_piece_index   = i_stage.idx;
            n_next_boundary = i_stage.word_a;
            n_wide_chars    = !desc[30];
            // With bit 30 set the offset is the descriptor minus bit 30, halved.
            n_file_offset   = desc[30] ? {1'b0, desc[31], 1'b0, desc[29:1]} : desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_stage.valid && (i_stage.op == ptpl_pkg::OP_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_found         <= n_found;
            r_piece_index   <= n_piece_index;
            r_next_boundary <= n_next_boundary;
            r_wide_chars    <= n_wide_chars;
            r_file_offset   <= n_file_offset;
        end
    end

    assign o_valid         = r_valid;
    assign o_found         = r_found;
    assign o_piece_index   = r_piece_index;
    assign o_next_boundary = r_next_boundary;
    assign o_wide_chars    = r_wide_chars;
    assign o_file_offset   = r_file_offset;

endmodule

@@ rtl/core/piece_table_position_lookup.sv @@
// ----------------------------------------------------------------------------
// Piece table position lookup
// Loads a document piece table and maps character positions to pieces.
// ----------------------------------------------------------------------------
// Every request (boundary write, descriptor write, query or no-op) enters a
// chain of MAX_PIECES cells and moves one cell per cycle. Cell K keeps the
// upper boundary of piece K and its descriptor, so a write settles in the one
// cell that owns its entry, and a query picks up the first piece whose upper
// boundary exceeds its position. The accepting edge loads the first cell, and
// the result register behind the last cell adds one more stage, so a query's
// result leaves the result register after it has walked every cell of the
// chain, and a stall holds it anywhere on the way. Requests stay in order, so
// a new request can be accepted every cycle, and the whole chain stalls only
// while a finished result waits at the output. Writes produce no result. The
// piece count is written over the APB port at byte address 0 and saturates at
// MAX_PIECES.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module piece_table_position_lookup #(
    parameter int MAX_PIECES = ptpl_pkg::MAX_PIECES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    // Request channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_opcode,
    input  logic [ptpl_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [ptpl_pkg::WORD_W-1:0] i_entry_value,
    input  logic [ptpl_pkg::WORD_W-1:0] i_query_position,

    // Result channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [ptpl_pkg::IDX_W-1:0]  o_piece_index,
    output logic [ptpl_pkg::WORD_W-1:0] o_next_boundary,
    output logic                        o_wide_chars,
    output logic [ptpl_pkg::WORD_W-1:0] o_file_offset
);

    localparam logic [31:0] MAX_W = 32'(MAX_PIECES);

    logic [ptpl_pkg::IDX_W-1:0] r_cnt;
    logic [ptpl_pkg::IDX_W-1:0] n_cnt;
    logic                       cfg_wr;
    logic                       adv;

    ptpl_pkg::t_stage chain [0:MAX_PIECES];

    // The piece count is the only register; it sits at byte address 0.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - ptpl_pkg::IDX_W){1'b0}}, r_cnt} : '0;

    always_comb begin
        n_cnt = r_cnt;
        if (cfg_wr) begin
            if ({{(32 - ptpl_pkg::IDX_W){1'b0}}, pwdata[ptpl_pkg::IDX_W-1:0]} > MAX_W) begin
                n_cnt = ptpl_pkg::IDX_W'(MAX_PIECES);
            end else begin
                n_cnt = pwdata[ptpl_pkg::IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // The chain moves as one; it holds only while a result waits untaken.
    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    always_comb begin
        chain[0].valid  = i_in_valid;
        chain[0].op     = ptpl_pkg::t_op'(i_opcode);
        chain[0].idx    = i_entry_index;
        chain[0].word_a = i_entry_value;
        chain[0].word_b = i_query_position;
        chain[0].hit    = 1'b0;
    end

    for (genvar k = 0; k < MAX_PIECES; k++) begin : g_cell
        ptpl_cell #(
            .K(k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_cnt   (r_cnt),
            .i_stage (chain[k]),
            .o_stage (chain[k+1])
        );
    end

    // A query that missed every cell reports the piece count and zero fields.
    ptpl_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_cnt           (r_cnt),
        .i_stage         (chain[MAX_PIECES]),
        .o_valid         (o_out_valid),
        .o_found         (o_found),
        .o_piece_index   (o_piece_index),
        .o_next_boundary (o_next_boundary),
        .o_wide_chars    (o_wide_chars),
        .o_file_offset   (o_file_offset)
    );

    `ASSERT_RST(a_cnt_range, i_clk, i_rst_n, (32'(r_cnt) <= MAX_W),
        "piece count above table size")
    `ASSERT_RST(a_miss_zero, i_clk, i_rst_n,
        (o_out_valid && !o_found) |-> (o_next_boundary == '0 && o_file_offset == '0
        && !o_wide_chars && o_piece_index == r_cnt), "miss result carries data")
    `ASSERT_RST(a_hit_index, i_clk, i_rst_n,
        (o_out_valid && o_found) |-> (o_piece_index < r_cnt), "hit index outside piece count")
    `ASSERT_RST(a_stall_hold, i_clk, i_rst_n,
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(chain[MAX_PIECES])),
        "chain moved during output stall")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piece table position lookup testbench
// Loads piece tables through the request channel, sets the piece count over
// the APB port and checks every lookup result against a local predictor.
// ----------------------------------------------------------------------------

module testbench;
    import ptpl_pkg::*;

    // The table depth matches the block's default size.
    localparam int TABLE_SIZE = MAX_PIECES_DEF;

    // Descriptor bit 30 marks a piece of 8-bit characters.
    localparam logic [WORD_W-1:0] NARROW_BIT        = 32'h4000_0000;
    localparam logic [WORD_W-1:0] NARROW_CLEAR_MASK = 32'hBFFF_FFFF;

    // APB byte addresses: the piece count is register 0, and the next slot
    // holds no register at all.
    localparam logic [2:0] PIECE_COUNT_ADDR = 3'd0;
    localparam logic [2:0] UNUSED_REG_ADDR  = 3'd4;

    localparam int MAX_GAP            = 17;
    localparam int RESULT_HOLD_CYCLES = 1200;
    // A request walks the whole cell chain, so writes that cause no result
    // may still be in flight after the last lookup has returned.
    localparam int SETTLE_CYCLES      = TABLE_SIZE + 32;
    localparam int WATCHDOG_LIMIT     = 6000;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   piece_index;
        logic [WORD_W-1:0]  next_boundary;
        logic               wide_chars;
        logic [WORD_W-1:0]  file_offset;
    } lookup_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n          = 1'b0;

    logic               psel             = 1'b0;
    logic               penable          = 1'b0;
    logic               pwrite           = 1'b0;
    logic [2:0]         paddr            = '0;
    logic [31:0]        pwdata           = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic               i_in_valid       = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_opcode         = '0;
    logic [IDX_W-1:0]   i_entry_index    = '0;
    logic [WORD_W-1:0]  i_entry_value    = '0;
    logic [WORD_W-1:0]  i_query_position = '0;

    logic               o_out_valid;
    logic               i_out_ready      = 1'b0;
    logic               o_found;
    logic [IDX_W-1:0]   o_piece_index;
    logic [WORD_W-1:0]  o_next_boundary;
    logic               o_wide_chars;
    logic [WORD_W-1:0]  o_file_offset;

    piece_table_position_lookup #(
        .MAX_PIECES (TABLE_SIZE)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_entry_index    (i_entry_index),
        .i_entry_value    (i_entry_value),
        .i_query_position (i_query_position),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_piece_index    (o_piece_index),
        .o_next_boundary  (o_next_boundary),
        .o_wide_chars     (o_wide_chars),
        .o_file_offset    (o_file_offset)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the piece table and the count.
    // Table words stay unknown until written; the stimulus never lets a
    // query read one of those.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]  boundary_words   [0:TABLE_SIZE];
    logic [WORD_W-1:0]  descriptor_words [0:TABLE_SIZE-1];
    logic [IDX_W-1:0]   piece_total = '0;
    lookup_result_t     expected_lookups [$];

    int                 error_count   = 0;
    int                 quiet_cycles  = 0;

    // Handshake shaping shared by the sender, the receiver and the tests.
    bit                 hold_results  = 1'b0;
    bit                 send_no_gaps  = 1'b0;
    int unsigned        send_burst_left = 0;
    int unsigned        recv_burst_left = 0;

    // Finds the first piece whose upper boundary lies above the position.
    // The lower boundary of piece 0 never takes part in the search.
    function automatic lookup_result_t lookup_position(logic [WORD_W-1:0] pos);
        lookup_result_t     res;
        logic [WORD_W-1:0]  desc;
        res = '0;
        res.piece_index = piece_total;
        for (int i = 0; i < int'(piece_total) && i < TABLE_SIZE; i++) begin
            if (boundary_words[i + 1] > pos) begin
                desc              = descriptor_words[i];
                res.found         = 1'b1;
                res.piece_index   = IDX_W'(i);
                res.next_boundary = boundary_words[i + 1];
                res.wide_chars    = ((desc & NARROW_BIT) == '0);
                res.file_offset   = res.wide_chars ? desc : ((desc & NARROW_CLEAR_MASK) >> 1);
                return res;
            end
        end
        // A position past the last piece reports the piece count and leaves the other fields at zero.
        return res;
    endfunction

    // Applies one accepted request to the predictor. Writes outside the table
    // and the no-op code change nothing.
    function automatic void apply_request(t_op op, logic [IDX_W-1:0] idx,
                                          logic [WORD_W-1:0] value,
                                          logic [WORD_W-1:0] pos);
        case (op)
            OP_WR_BND: begin
                if (idx <= TABLE_SIZE) boundary_words[idx] = value;
            end
            OP_WR_DESC: begin
                if (idx < TABLE_SIZE) descriptor_words[idx] = value;
            end
            OP_QUERY: begin
                expected_lookups.push_back(lookup_position(pos));
            end
            default: begin
            end
        endcase
    endfunction

    // True for requests that the block acts on rather than drops.
    function automatic bit takes_effect(t_op op, logic [IDX_W-1:0] idx);
        return (op == OP_QUERY) || (op == OP_WR_BND && idx <= TABLE_SIZE) ||
               (op == OP_WR_DESC && idx < TABLE_SIZE);
    endfunction

    // Picks a query position around one of the live boundaries, so that the
    // search lands on both sides of every edge, with some fully random ones.
    function automatic logic [WORD_W-1:0] pick_position();
        int unsigned        k;
        logic [WORD_W-1:0]  base;
        k    = $urandom_range(0, int'(piece_total));
        base = boundary_words[k];
        case ($urandom_range(0, 4))
            0:       return base - 1;
            1:       return base;
            2:       return base + 1;
            3:       return $urandom;
            default: return base + $urandom_range(0, 4095);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request sender. Each call starts right after a rising edge and returns
    // at the edge that accepted the request. The gap before a request is
    // drawn at random, with occasional bursts of back-to-back requests.
    // ------------------------------------------------------------------
    task automatic send_request(t_op op, logic [IDX_W-1:0] idx,
                                logic [WORD_W-1:0] value, logic [WORD_W-1:0] pos);
        int unsigned gap;
        if (send_no_gaps) begin
            gap = 0;
        end else if (send_burst_left > 0) begin
            gap = 0;
            send_burst_left--;
        end else if ($urandom_range(0, 24) == 0) begin
            gap = 0;
            send_burst_left = $urandom_range(20, 60);
        end else begin
            gap = $urandom_range(0, MAX_GAP);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_opcode         <= op;
        i_entry_index    <= idx;
        i_entry_value    <= value;
        i_query_position <= pos;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        apply_request(op, idx, value, pos);
    endtask

    // Stops offering requests, waits for every outstanding lookup and then
    // lets any trailing writes walk out of the cell chain.
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_lookups.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: a setup cycle, then an access cycle that completes at the
    // edge where pready is seen high. The bus returns to idle after every access.
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        // The count keeps only its low nine bits and saturates at the depth.
        if (addr == PIECE_COUNT_ADDR)
            piece_total = (data[IDX_W-1:0] > TABLE_SIZE) ? IDX_W'(TABLE_SIZE)
                                                         : data[IDX_W-1:0];
        @(posedge i_clk);
    endtask

    // APB read of the piece count, checked against the predictor.
    task automatic apb_read_count();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PIECE_COUNT_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== 32'(piece_total)) begin
            $error("piece_count: expected %0d, got %0d", piece_total, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // The count is only changed once the block has gone quiet.
    task automatic set_piece_count(logic [31:0] data);
        wait_for_idle();
        apb_write(PIECE_COUNT_ADDR, data);
        apb_read_count();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset the count is zero, so a query touches no table word
    // and must report a miss at piece 0. The no-op code must stay silent.
    task automatic test_reset_state();
        apb_read_count();
        send_request(OP_QUERY, IDX_W'($urandom), $urandom, $urandom);
        send_request(OP_NOP, IDX_W'($urandom), $urandom, $urandom);
        send_request(OP_QUERY, IDX_W'($urandom), $urandom, 32'hFFFF_FFFF);
    endtask

    // A four-piece table with hand-picked boundaries and one descriptor of
    // each kind, probed at and around every boundary.
    task automatic test_directed_lookups();
        logic [WORD_W-1:0] bounds [5];
        logic [WORD_W-1:0] descs  [4];
        logic [WORD_W-1:0] probes [10];
        bounds = '{32'd100, 32'd200, 32'd300, 32'h8000_0000, 32'hFFFF_FFFF};
        // Narrow with every bit set, wide zero, narrow zero, wide with every
        // bit but the narrow flag set.
        descs  = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h4000_0000, 32'hBFFF_FFFF};
        // The first probes sit below the lower boundary of piece 0; the last
        // one lies past the final piece.
        probes = '{32'd0, 32'd99, 32'd199, 32'd200, 32'd299, 32'd300,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
        foreach (bounds[k]) send_request(OP_WR_BND, IDX_W'(k), bounds[k], $urandom);
        foreach (descs[k]) send_request(OP_WR_DESC, IDX_W'(k), descs[k], $urandom);
        // Writes past the end of either store must be dropped.
        send_request(OP_WR_BND, IDX_W'(TABLE_SIZE + 1), 32'd0, $urandom);
        send_request(OP_WR_BND, '1, 32'd0, $urandom);
        send_request(OP_WR_DESC, IDX_W'(TABLE_SIZE), 32'd0, $urandom);
        send_request(OP_WR_DESC, '1, 32'd0, $urandom);
        set_piece_count(32'd4);
        foreach (probes[k]) send_request(OP_QUERY, IDX_W'($urandom), $urandom, probes[k]);
    endtask

    // Fills both stores completely with a sorted boundary list and random
    // descriptors, so that any count leaves no unwritten word in reach.
    task automatic load_piece_table();
        logic [63:0] mark;
        mark = 64'($urandom_range(0, 1000));
        for (int k = 0; k <= TABLE_SIZE; k++) begin
            send_request(OP_WR_BND, IDX_W'(k), mark[WORD_W-1:0], $urandom);
            mark = mark + 64'($urandom_range(1, 24'hFF_FFFF));
            if (mark > 64'hFFFF_FFFF) mark = 64'hFFFF_FFFF;
        end
        for (int k = 0; k < TABLE_SIZE; k++)
            send_request(OP_WR_DESC, IDX_W'(k), $urandom, $urandom);
    endtask

    // Full, saturated, masked, zero and single-piece counts, plus a write to
    // an address that holds no register.
    task automatic test_piece_count_extremes();
        set_piece_count(TABLE_SIZE);
        send_request(OP_QUERY, IDX_W'($urandom), $urandom, boundary_words[TABLE_SIZE] - 1);
        send_request(OP_QUERY, IDX_W'($urandom), $urandom, boundary_words[TABLE_SIZE]);
        send_request(OP_QUERY, IDX_W'($urandom), $urandom, 32'hFFFF_FFFF);
        set_piece_count(32'd300);
        send_request(OP_QUERY, IDX_W'($urandom), $urandom, boundary_words[TABLE_SIZE - 1]);
        set_piece_count(32'hFFFF_FE05);
        apb_write(UNUSED_REG_ADDR, $urandom);
        apb_read_count();
        send_request(OP_QUERY, IDX_W'($urandom), $urandom, boundary_words[5]);
        set_piece_count(32'd0);
        send_request(OP_QUERY, IDX_W'($urandom), $urandom, 32'd0);
        set_piece_count(32'd1);
        send_request(OP_QUERY, IDX_W'($urandom), $urandom, boundary_words[1] - 1);
        send_request(OP_QUERY, IDX_W'($urandom), $urandom, boundary_words[1]);
        set_piece_count(TABLE_SIZE);
    endtask

    // The receiver holds off for a long stretch while queries keep coming
    // back to back, so the chain fills and the request channel must stall.
    task automatic test_result_backpressure();
        hold_results = 1'b1;
        send_no_gaps = 1'b1;
        repeat (320) send_request(OP_QUERY, IDX_W'($urandom), $urandom, pick_position());
        send_no_gaps = 1'b0;
    endtask

    // Rounds of mixed traffic, each under its own piece count. Most requests
    // are queries and well-formed table updates that keep the boundaries
    // sorted; the rest are raw writes anywhere and no-ops.
    task automatic test_random_traffic(int unsigned target);
        int unsigned        done;
        int unsigned        round_end;
        int unsigned        round;
        int unsigned        pick;
        int unsigned        k;
        logic [31:0]        cfg;
        logic [WORD_W-1:0]  lo;
        logic [WORD_W-1:0]  hi;
        logic [WORD_W-1:0]  value;
        logic [WORD_W-1:0]  pos;
        logic [63:0]        span;
        logic [IDX_W-1:0]   idx;
        t_op                op;
        done  = 0;
        round = 0;
        while (done < target) begin
            // Upper bits of the count write are random; only the low nine
            // bits carry the count.
            cfg = $urandom;
            case (round % 5)
                0:       cfg[IDX_W-1:0] = 9'd1;
                1:       cfg[IDX_W-1:0] = IDX_W'(TABLE_SIZE);
                2:       cfg[IDX_W-1:0] = IDX_W'($urandom_range(2, 16));
                3:       cfg[IDX_W-1:0] = IDX_W'($urandom_range(17, TABLE_SIZE - 1));
                default: cfg[IDX_W-1:0] = IDX_W'($urandom_range(0, 511));
            endcase
            set_piece_count(cfg);
            round_end = done + 140;
            while (done < round_end && done < target) begin
                pick  = $urandom_range(0, 99);
                idx   = IDX_W'($urandom);
                value = $urandom;
                pos   = $urandom;
                if (pick < 65) begin
                    op  = OP_QUERY;
                    pos = pick_position();
                end else if (pick < 80) begin
                    // Move one boundary between its neighbors.
                    op  = OP_WR_BND;
                    k   = $urandom_range(1, TABLE_SIZE);
                    idx = IDX_W'(k);
                    lo  = boundary_words[k - 1];
                    hi  = (k == TABLE_SIZE) ? '1 : boundary_words[k + 1];
                    if (hi >= lo) begin
                        span  = 64'(hi) - 64'(lo) + 64'd1;
                        value = lo + WORD_W'({$urandom, $urandom} % span);
                    end
                end else if (pick < 88) begin
                    op  = OP_WR_DESC;
                    idx = IDX_W'($urandom_range(0, TABLE_SIZE - 1));
                end else if (pick < 94) begin
                    op  = t_op'($urandom_range(0, 1));
                    idx = IDX_W'($urandom_range(0, 511));
                end else begin
                    op  = OP_NOP;
                end
                send_request(op, idx, value, pos);
                if (takes_effect(op, idx)) done++;
            end
            round++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence. Reset is applied once at the start and never again.
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed_lookups();
        load_piece_table();
        test_piece_count_extremes();
        test_result_backpressure();
        test_random_traffic(700);
        wait_for_idle();
        if (expected_lookups.size() != 0) begin
            $error("%0d lookups never returned", expected_lookups.size());
            error_count++;
        end
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result receiver. Before each result it waits a random number of
    // cycles, sometimes none for a stretch, and once it holds off for a
    // long time on request from the backpressure test.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned gap;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_results) begin
                i_out_ready <= 1'b0;
                repeat (RESULT_HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end
            if (recv_burst_left > 0) begin
                gap = 0;
                recv_burst_left--;
            end else if ($urandom_range(0, 24) == 0) begin
                gap = 0;
                recv_burst_left = $urandom_range(20, 60);
            end else begin
                gap = $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Result checker. Every accepted result is compared field by field with
    // the oldest outstanding lookup.
    // ------------------------------------------------------------------
    function automatic void compare_field(string name, logic [WORD_W-1:0] want,
                                          logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        lookup_result_t want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_lookups.size() == 0) begin
                $error("lookup result arrived with no query outstanding");
                error_count++;
            end else begin
                want = expected_lookups.pop_front();
                compare_field("found", 32'(want.found), 32'(o_found));
                compare_field("piece_index", 32'(want.piece_index), 32'(o_piece_index));
                compare_field("next_boundary", want.next_boundary, o_next_boundary);
                compare_field("wide_chars", 32'(want.wide_chars), 32'(o_wide_chars));
                compare_field("file_offset", want.file_offset, o_file_offset);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog. Any handshake on either channel or the APB port counts as
    // progress; a long run of cycles without one ends the simulation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready === 1'b1) ||
            (o_out_valid === 1'b1 && i_out_ready) ||
            (psel && penable && pready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

@@ piece_table_position_lookup.f @@
+incdir+rtl/core
rtl/core/ptpl_pkg.sv
rtl/core/ptpl_cell.sv
rtl/core/ptpl_out.sv
rtl/core/piece_table_position_lookup.sv
dv/testbench.sv
